// File: hdl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, constants, arctangent table and payload types for the
// quaternion to roll/pitch/yaw pipeline.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int SAMPLE_WIDTH  = 16;
    localparam int FRAC_BITS     = SAMPLE_WIDTH - 2;
    localparam int PROD_SHL      = 30 - 2 * FRAC_BITS;   // product to Q30
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_LEN      = 24;

    localparam int XW     = 40;   // CORDIC x/y and Q30 term width
    localparam int ZW     = 34;   // Q29 angle accumulator
    localparam int PW     = 2 * SAMPLE_WIDTH;
    localparam int MAG_W  = 30;
    localparam int REM_W  = 61;
    localparam int ISQ_W  = 31;
    localparam int TRY_W  = 63;

    localparam int PRE_STAGES = 5;
    localparam int NUM_STAGES = PRE_STAGES + ISQ_W + 1 + CORDIC_STAGES + 1;

    localparam logic signed [XW-1:0] ONE_Q30     = XW'(64'sd1073741824);
    localparam logic signed [XW-1:0] M_ONE_Q30   = -ONE_Q30;
    localparam logic signed [ZW-1:0] HALF_PI_Q29 = ZW'(64'sd843314857);
    localparam logic signed [ZW-1:0] PI_Q13      = ZW'(64'sd25736);
    localparam logic signed [ZW-1:0] HALF_PI_Q13 = ZW'(64'sd12868);

    typedef struct packed {
        logic signed [XW-1:0] sr;
        logic signed [XW-1:0] cr;
        logic signed [XW-1:0] sy;
        logic signed [XW-1:0] cy;
        logic signed [XW-1:0] sp;
        logic                 sp_neg;
        logic                 clamp;
    } side_t;

    typedef struct packed {
        logic flag_a;   // pitch: clamp; roll/yaw: unused
        logic flag_b;   // pitch: negative; roll/yaw: both terms zero
    } tag_t;

    function automatic logic signed [ZW-1:0] atan_q29(input int i);
        logic signed [ZW-1:0] r;
        case (i)
            0:  r = ZW'(64'sd421657428);
            1:  r = ZW'(64'sd248918915);
            2:  r = ZW'(64'sd131521918);
            3:  r = ZW'(64'sd66762579);
            4:  r = ZW'(64'sd33510843);
            5:  r = ZW'(64'sd16771758);
            6:  r = ZW'(64'sd8387925);
            7:  r = ZW'(64'sd4194219);
            8:  r = ZW'(64'sd2097141);
            9:  r = ZW'(64'sd1048575);
            10: r = ZW'(64'sd524288);
            11: r = ZW'(64'sd262144);
            12: r = ZW'(64'sd131072);
            13: r = ZW'(64'sd65536);
            14: r = ZW'(64'sd32768);
            15: r = ZW'(64'sd16384);
            16: r = ZW'(64'sd8192);
            17: r = ZW'(64'sd4096);
            18: r = ZW'(64'sd2048);
            19: r = ZW'(64'sd1024);
            20: r = ZW'(64'sd512);
            21: r = ZW'(64'sd256);
            22: r = ZW'(64'sd128);
            23: r = ZW'(64'sd64);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/qte_isqrt.sv
// ----------------------------------------------------------------------------
// qte_isqrt
// Pipelined floor square root, one result bit per stage, carrying the side
// payload alongside.
// ----------------------------------------------------------------------------
module qte_isqrt
    import qte_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [REM_W-1:0] rest_in,
    input  side_t            side_in,
    output logic [ISQ_W-1:0] root_out,
    output side_t            side_out
);

    logic [REM_W-1:0] rem_reg  [ISQ_W];
    logic [ISQ_W-1:0] root_reg [ISQ_W];
    side_t            side_reg [ISQ_W];

    for (genvar j = 0; j < ISQ_W; j++) begin : g_stage
        localparam int K = ISQ_W - 1 - j;
        logic [REM_W-1:0] rem_prev;
        logic [ISQ_W-1:0] root_prev;
        side_t            side_prev;
        logic [TRY_W-1:0] trial;
        logic [TRY_W-1:0] rem_ext;

        if (j == 0) begin : g_first
            assign rem_prev  = rest_in;
            assign root_prev = '0;
            assign side_prev = side_in;
        end
        else begin : g_next
            assign rem_prev  = rem_reg[j-1];
            assign root_prev = root_reg[j-1];
            assign side_prev = side_reg[j-1];
        end

        // (root + 2^k)^2 <= v  <=>  rem >= root*2^(k+1) + 2^(2k)
        assign trial   = (TRY_W'(root_prev) << (K + 1)) + (TRY_W'(1) << (2 * K));
        assign rem_ext = TRY_W'(rem_prev);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[j] <= side_prev;
                if (rem_ext >= trial)
                begin
                    rem_reg[j]  <= REM_W'(rem_ext - trial);
                    root_reg[j] <= root_prev | (ISQ_W'(1) << K);
                end
                else
                begin
                    rem_reg[j]  <= rem_prev;
                    root_reg[j] <= root_prev;
                end
            end
        end
    end

    assign root_out = root_reg[ISQ_W-1];
    assign side_out = side_reg[ISQ_W-1];

endmodule

// File: hdl/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC, one micro-rotation per stage; angle in Q29.
// ----------------------------------------------------------------------------
module qte_cordic
    import qte_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [XW-1:0] x_in,
    input  logic signed [XW-1:0] y_in,
    input  logic signed [ZW-1:0] z_in,
    input  tag_t                 tag_in,
    output logic signed [ZW-1:0] z_out,
    output tag_t                 tag_out
);

    logic signed [XW-1:0] x_reg   [CORDIC_STAGES];
    logic signed [XW-1:0] y_reg   [CORDIC_STAGES];
    logic signed [ZW-1:0] z_reg   [CORDIC_STAGES];
    tag_t                 tag_reg [CORDIC_STAGES];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        localparam logic signed [ZW-1:0] ANG = atan_q29(i);
        logic signed [XW-1:0] xp, yp;
        logic signed [ZW-1:0] zp;
        tag_t                 tp;

        if (i == 0) begin : g_first
            assign xp = x_in;
            assign yp = y_in;
            assign zp = z_in;
            assign tp = tag_in;
        end
        else begin : g_next
            assign xp = x_reg[i-1];
            assign yp = y_reg[i-1];
            assign zp = z_reg[i-1];
            assign tp = tag_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tag_reg[i] <= tp;
                if (!yp[XW-1])
                begin
                    x_reg[i] <= xp + (yp >>> i);
                    y_reg[i] <= yp - (xp >>> i);
                    z_reg[i] <= zp + ANG;
                end
                else
                begin
                    x_reg[i] <= xp - (yp >>> i);
                    y_reg[i] <= yp + (xp >>> i);
                    z_reg[i] <= zp - ANG;
                end
            end
        end
    end

    assign z_out   = z_reg[CORDIC_STAGES-1];
    assign tag_out = tag_reg[CORDIC_STAGES-1];

endmodule

// File: hdl/quaternion_to_euler_angles_core.sv
// Throughput: one quaternion per cycle while out_ready does not stall the output;
// set by the fully pipelined square root (one bit per stage) and CORDIC
// (one rotation per stage) chains.
// Whole pipeline advances together; the input stage also fills when empty.
// Reset clears all valid bits asynchronously; payload registers are not reset.
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_core
// Unit quaternion (Q1.14) to ZYX roll, pitch and yaw (Q2.13 radians).
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_core
    import qte_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] quat_w,
    input  logic signed [SAMPLE_WIDTH-1:0] quat_x,
    input  logic signed [SAMPLE_WIDTH-1:0] quat_y,
    input  logic signed [SAMPLE_WIDTH-1:0] quat_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [15:0]            roll_angle,
    output logic signed [14:0]            pitch_angle,
    output logic signed [15:0]            yaw_angle,
    output logic                          pitch_clamped
);

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } rot_t;

    // left half plane turned by +/- pi/2 before the rotations
    function automatic rot_t prerot(input logic signed [XW-1:0] ys,
                                    input logic signed [XW-1:0] xs);
        rot_t r;
        r.zero = (xs == '0) && (ys == '0);
        r.x    = xs;
        r.y    = ys;
        r.z    = '0;
        if (xs[XW-1])
        begin
            if (!ys[XW-1])
            begin
                r.x = ys;
                r.y = -xs;
                r.z = HALF_PI_Q29;
            end
            else
            begin
                r.x = -ys;
                r.y = xs;
                r.z = -HALF_PI_Q29;
            end
        end
        return r;
    endfunction

    function automatic logic signed [ZW-1:0] to_q13(input logic signed [ZW-1:0] z,
                                                   input logic signed [ZW-1:0] lim);
        logic signed [ZW-1:0] r;
        r = (z + ZW'(64'sd32768)) >>> 16;
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r;
    endfunction

    logic [NUM_STAGES-1:0] v_reg;
    logic                  pipe_en;
    logic                  en0;

    assign pipe_en  = !v_reg[NUM_STAGES-1] || out_ready;
    assign en0      = pipe_en || !v_reg[0];
    assign in_ready = en0;
    assign out_valid = v_reg[NUM_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en0)
                v_reg[0] <= in_valid;
            if (pipe_en)
                v_reg[NUM_STAGES-1:1] <= v_reg[NUM_STAGES-2:0];
        end
    end

    // stage 0: input register
    logic signed [SAMPLE_WIDTH-1:0] w_reg, x_reg, y_reg, z_reg;
    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            w_reg <= quat_w;
            x_reg <= quat_x;
            y_reg <= quat_y;
            z_reg <= quat_z;
        end
    end

    // stage 1: products
    logic signed [PW-1:0] wx_reg, yz_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PW-1:0] wy_reg, zx_reg, wz_reg, xy_reg;
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            wx_reg <= w_reg * x_reg;
            yz_reg <= y_reg * z_reg;
            xx_reg <= x_reg * x_reg;
            yy_reg <= y_reg * y_reg;
            zz_reg <= z_reg * z_reg;
            wy_reg <= w_reg * y_reg;
            zx_reg <= z_reg * x_reg;
            wz_reg <= w_reg * z_reg;
            xy_reg <= x_reg * y_reg;
        end
    end

    // stage 2: Q30 terms, doubled
    logic signed [XW-1:0] sr_reg, cr_reg, sp_reg, sy_reg, cy_reg;
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            sr_reg <= (XW'(wx_reg) + XW'(yz_reg)) <<< (PROD_SHL + 1);
            cr_reg <= ONE_Q30 - ((XW'(xx_reg) + XW'(yy_reg)) <<< (PROD_SHL + 1));
            sp_reg <= (XW'(wy_reg) - XW'(zx_reg)) <<< (PROD_SHL + 1);
            sy_reg <= (XW'(wz_reg) + XW'(xy_reg)) <<< (PROD_SHL + 1);
            cy_reg <= ONE_Q30 - ((XW'(yy_reg) + XW'(zz_reg)) <<< (PROD_SHL + 1));
        end
    end

    // stage 3: pitch saturation and magnitude
    side_t             side3_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic signed [XW-1:0] sp_abs;
    assign sp_abs = sp_reg[XW-1] ? -sp_reg : sp_reg;
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            side3_reg.sr     <= sr_reg;
            side3_reg.cr     <= cr_reg;
            side3_reg.sy     <= sy_reg;
            side3_reg.cy     <= cy_reg;
            side3_reg.sp     <= sp_reg;
            side3_reg.sp_neg <= sp_reg[XW-1];
            side3_reg.clamp  <= (sp_reg >= ONE_Q30) || (sp_reg <= M_ONE_Q30);
            mag_reg          <= sp_abs[MAG_W-1:0];
        end
    end

    // stage 4: 1 - s^2 in Q60 (meaningless when clamped)
    side_t            side4_reg;
    logic [REM_W-1:0] rest_reg;
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            side4_reg <= side3_reg;
            rest_reg  <= (REM_W'(1) << 60) - REM_W'(mag_reg * mag_reg);
        end
    end

    logic [ISQ_W-1:0] root;
    side_t            side_q;

    qte_isqrt u_isqrt (
        .clk      (clk),
        .en       (pipe_en),
        .rest_in  (rest_reg),
        .side_in  (side4_reg),
        .root_out (root),
        .side_out (side_q)
    );

    // pre-rotation stage
    rot_t roll_rot, yaw_rot;
    assign roll_rot = prerot(side_q.sr, side_q.cr);
    assign yaw_rot  = prerot(side_q.sy, side_q.cy);

    rot_t                 roll_p_reg, yaw_p_reg;
    logic signed [XW-1:0] px_reg, py_reg;
    tag_t                 ptag_reg;
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            roll_p_reg      <= roll_rot;
            yaw_p_reg       <= yaw_rot;
            px_reg          <= XW'(root);
            py_reg          <= side_q.sp;
            ptag_reg.flag_a <= side_q.clamp;
            ptag_reg.flag_b <= side_q.sp_neg;
        end
    end

    logic signed [ZW-1:0] roll_z, pitch_z, yaw_z;
    tag_t                 roll_t, pitch_t, yaw_t;
    tag_t                 roll_tag_in, yaw_tag_in;

    assign roll_tag_in = '{flag_a: 1'b0, flag_b: roll_p_reg.zero};
    assign yaw_tag_in  = '{flag_a: 1'b0, flag_b: yaw_p_reg.zero};

    qte_cordic u_roll (
        .clk (clk), .en (pipe_en),
        .x_in (roll_p_reg.x), .y_in (roll_p_reg.y), .z_in (roll_p_reg.z),
        .tag_in (roll_tag_in), .z_out (roll_z), .tag_out (roll_t)
    );

    qte_cordic u_pitch (
        .clk (clk), .en (pipe_en),
        .x_in (px_reg), .y_in (py_reg), .z_in ('0),
        .tag_in (ptag_reg), .z_out (pitch_z), .tag_out (pitch_t)
    );

    qte_cordic u_yaw (
        .clk (clk), .en (pipe_en),
        .x_in (yaw_p_reg.x), .y_in (yaw_p_reg.y), .z_in (yaw_p_reg.z),
        .tag_in (yaw_tag_in), .z_out (yaw_z), .tag_out (yaw_t)
    );

    // output stage: round to Q2.13 and clamp
    logic signed [ZW-1:0] roll_r, pitch_r, yaw_r;
    assign roll_r  = roll_t.flag_b ? '0 : to_q13(roll_z, PI_Q13);
    assign yaw_r   = yaw_t.flag_b ? '0 : to_q13(yaw_z, PI_Q13);
    assign pitch_r = pitch_t.flag_a ? (pitch_t.flag_b ? -HALF_PI_Q13 : HALF_PI_Q13)
                                    : to_q13(pitch_z, HALF_PI_Q13);

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            roll_angle    <= roll_r[15:0];
            pitch_angle   <= pitch_r[14:0];
            yaw_angle     <= yaw_r[15:0];
            pitch_clamped <= pitch_t.flag_a;
        end
    end

    a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pitch_clamped |-> (pitch_angle == 15'sd12868 ||
                                        pitch_angle == -15'sd12868))
        else $error("clamped pitch not at +/- pi/2");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (roll_angle <= 16'sd25736 && roll_angle >= -16'sd25736 &&
                       yaw_angle <= 16'sd25736 && yaw_angle >= -16'sd25736))
        else $error("roll or yaw outside +/- pi");

    a_fill_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[0] |-> in_ready)
        else $error("empty input stage refused a transfer");

endmodule

// File: verif/tb_quaternion_to_euler_angles_core.sv
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_angles_core
// Feeds quaternions through the core with random gaps and output stalls and
// compares every roll/pitch/yaw result to a bit-exact model or a hand value.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler_angles_core
    import qte_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM   = 1030;
    localparam int DRAIN_WAIT = 2 * NUM_STAGES + 20;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic               clamped;
    } euler_t;

    typedef struct {
        int     w, x, y, z;
        bit     fixed;      // expected result written in by hand
        euler_t res;
    } quat_row_t;

    localparam longint ONE_Q30_L = 64'sd1 << 30;
    localparam longint HALF_PI_L = 64'sd843314857;
    localparam longint ATAN_TAB [24] = '{
        421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
        8387925, 4194219, 2097141, 1048575, 524288, 262144,
        131072, 65536, 32768, 16384, 8192, 4096,
        2048, 1024, 512, 256, 128, 64};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [SAMPLE_WIDTH-1:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] roll_angle;
    logic signed [14:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic pitch_clamped;

    // hand-written expectation travelling with the payload being offered
    bit     cur_fixed = 1'b0;
    euler_t cur_res   = '0;

    euler_t angles_due [$];
    int     n_mismatch = 0;
    bit     sending_done = 1'b0;

    always #6 clk = ~clk;

    quaternion_to_euler_angles_core dut (.*);

    // ---------------------------------------------------------------- model
    function automatic longint prod_q30(longint a, longint b);
        longint p;
        int sh;
        p  = a * b;
        sh = 2 * FRAC_BITS - 30;
        if (sh >= 0)
            return p >>> sh;
        return p <<< (-sh);
    endfunction

    function automatic longint atan2_q29(longint sn, longint cs);
        longint ang, t, dx, dy;
        ang = 0;
        if (cs == 0 && sn == 0)
            return 0;
        // left half plane: pre-rotate by a quarter turn
        if (cs < 0) begin
            t = cs;
            if (sn >= 0) begin
                cs = sn; sn = -t; ang = HALF_PI_L;
            end
            else begin
                cs = -sn; sn = t; ang = -HALF_PI_L;
            end
        end
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            dx = sn >>> i;
            dy = cs >>> i;
            if (sn >= 0) begin
                cs += dx; sn -= dy; ang += ATAN_TAB[i];
            end
            else begin
                cs -= dx; sn += dy; ang -= ATAN_TAB[i];
            end
        end
        return ang;
    endfunction

    function automatic longint round_q13(longint a, longint lim);
        longint r;
        r = (a + (64'sd1 << 15)) >>> 16;
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v  -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic euler_t quat_to_euler(longint w, longint x, longint y, longint z);
        euler_t e;
        longint sr, cr, sp, sy, cy, mag;
        longint unsigned rest;
        sr = 2 * (prod_q30(w, x) + prod_q30(y, z));
        cr = ONE_Q30_L - 2 * (prod_q30(x, x) + prod_q30(y, y));
        sp = 2 * (prod_q30(w, y) - prod_q30(z, x));
        sy = 2 * (prod_q30(w, z) + prod_q30(x, y));
        cy = ONE_Q30_L - 2 * (prod_q30(y, y) + prod_q30(z, z));
        e.roll = 16'(round_q13(atan2_q29(sr, cr), 25736));
        e.yaw  = 16'(round_q13(atan2_q29(sy, cy), 25736));
        if (sp >= ONE_Q30_L) begin
            e.pitch = 15'(12868); e.clamped = 1'b1;
        end
        else if (sp <= -ONE_Q30_L) begin
            e.pitch = -15'sd12868; e.clamped = 1'b1;
        end
        else begin
            mag  = (sp < 0) ? -sp : sp;
            rest = (64'd1 << 60) - longint'(mag * mag);
            e.pitch   = 15'(round_q13(atan2_q29(sp, longint'(int_sqrt(rest))), 12868));
            e.clamped = 1'b0;
        end
        return e;
    endfunction

    // ---------------------------------------------------------------- checking
    task automatic report_mismatch(string field, longint got, longint want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
        n_mismatch++;
    endtask

    always @(posedge clk) begin
        euler_t e;
        if (in_valid && in_ready) begin
            if (cur_fixed)
                angles_due.push_back(cur_res);
            else
                angles_due.push_back(quat_to_euler(quat_w, quat_x, quat_y, quat_z));
        end
        if (out_valid && out_ready) begin
            if (angles_due.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else begin
                e = angles_due.pop_front();
                if (roll_angle !== e.roll)
                    report_mismatch("roll_angle", roll_angle, e.roll);
                if (pitch_angle !== e.pitch)
                    report_mismatch("pitch_angle", pitch_angle, e.pitch);
                if (yaw_angle !== e.yaw)
                    report_mismatch("yaw_angle", yaw_angle, e.yaw);
                if (pitch_clamped !== e.clamped)
                    report_mismatch("pitch_clamped", pitch_clamped, e.clamped);
            end
        end
    end

    // ---------------------------------------------------------------- stimulus
    bit calm_in = 1'b0;

    task automatic offer_quat(quat_row_t r);
        int gap;
        gap = calm_in ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        quat_w    <= SAMPLE_WIDTH'(r.w);
        quat_x    <= SAMPLE_WIDTH'(r.x);
        quat_y    <= SAMPLE_WIDTH'(r.y);
        quat_z    <= SAMPLE_WIDTH'(r.z);
        cur_fixed <= r.fixed;
        cur_res   <= r.res;
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic quat_row_t random_quat();
        quat_row_t r;
        real a [4];
        real nrm;
        r.fixed = 1'b0;
        r.res   = '0;
        if ($urandom_range(0, 9) < 7) begin
            // unit quaternion with random direction
            nrm = 0.0;
            foreach (a[i]) begin
                a[i] = real'(int'($urandom_range(0, 65536)) - 32768);
                nrm += a[i] * a[i];
            end
            if (nrm == 0.0) begin
                a[0] = 1.0; nrm = 1.0;
            end
            nrm = $sqrt(nrm);
            r.w = $rtoi(a[0] / nrm * 16384.0);
            r.x = $rtoi(a[1] / nrm * 16384.0);
            r.y = $rtoi(a[2] / nrm * 16384.0);
            r.z = $rtoi(a[3] / nrm * 16384.0);
        end
        else begin
            // raw bit patterns, any value the port can carry
            r.w = int'($urandom_range(0, 65535)) - 32768;
            r.x = int'($urandom_range(0, 65535)) - 32768;
            r.y = int'($urandom_range(0, 65535)) - 32768;
            r.z = int'($urandom_range(0, 65535)) - 32768;
        end
        return r;
    endfunction

    quat_row_t directed [] = '{
        '{16384, 0, 0, 0, 1'b1, '0},            // identity
        '{0, 0, 0, 0, 1'b1, '0},                // all products zero
        '{0, 0, 0, 16384, 1'b0, '0},            // yaw of pi
        '{0, 16384, 0, 0, 1'b0, '0},            // roll of pi
        '{16384, 0, 16384, 0, 1'b0, '0},        // pitch saturates high
        '{16384, 0, -16384, 0, 1'b0, '0},       // pitch saturates low
        '{11585, 0, 11585, 0, 1'b0, '0},        // just under saturation
        '{11586, 0, 11586, 0, 1'b0, '0},        // just over
        '{0, 8192, 8192, 0, 1'b0, '0},          // atan2 of zero, zero
        '{0, 0, 8192, 8192, 1'b0, '0},
        '{8192, -8192, 8192, -8192, 1'b0, '0},
        '{-8192, 8192, -8192, 8192, 1'b0, '0},
        '{-16384, -16384, -16384, -16384, 1'b0, '0},
        '{16384, 16384, 16384, 16384, 1'b0, '0},
        '{-32768, -32768, -32768, -32768, 1'b0, '0},
        '{32767, 32767, 32767, 32767, 1'b0, '0},
        '{32767, -32768, 32767, -32768, 1'b0, '0},
        '{0, 11585, 0, -11585, 1'b0, '0},       // pitch just under saturation, roll and yaw sines zero
        '{1, -1, 1, -1, 1'b0, '0},
        '{-1, 1, -1, 1, 1'b0, '0},
        '{21845, -10923, 5461, -2731, 1'b0, '0} // alternating bit patterns
    };

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            offer_quat(directed[i]);
        in_valid <= 1'b0;
        // hold off until the pipe has fully drained
        wait (angles_due.size() == 0);
        @(posedge clk);
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 0)
                calm_in = ($urandom_range(0, 3) == 0);
            offer_quat(random_quat());
        end
        in_valid     <= 1'b0;
        sending_done <= 1'b1;
    end

    // result side stalls
    initial begin
        int stall;
        bit calm_out;
        calm_out = 1'b0;
        repeat (8) @(posedge clk);
        forever begin
            if ($urandom_range(0, 99) == 0)
                calm_out = ~calm_out;
            stall = calm_out ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin
        wait (sending_done);
        wait (angles_due.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (n_mismatch == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
